FILE: sv/etad_pkg.sv
// Shared types and constants for the echo time averaging distance block.
// Used by the top, datapath and controller; depends on nothing else.
`timescale 1ns / 1ps

package etad_pkg;

    // Field and register widths.
    localparam int ECHO_W     = 32;
    localparam int WIN_REG_W  = 5;
    localparam int SPEED_W    = 10;
    localparam int DIST_W     = 21;
    localparam int PROD_W     = ECHO_W + SPEED_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // Default history depth.
    localparam int MAX_WINDOW_DEF = 16;

    // Register reset values.
    localparam logic [WIN_REG_W-1:0] WINDOW_RESET = WIN_REG_W'(5);
    localparam logic [SPEED_W-1:0]   SPEED_RESET  = SPEED_W'(343);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SOUND_SPEED   = 1'b1;

    // The scale divisor 4000000 is 2^8 * 15625. The product is shifted right by 8,
    // then multiplied by ceil(2^47 / 15625), taken as two 17-bit halves. Bits 47 and
    // up of that product are the exact quotient by 15625 for any 34-bit value.
    localparam int SCALE_SHIFT  = 8;
    localparam int SCALED_W     = PROD_W - SCALE_SHIFT;
    localparam int RECIP_PART_W = 17;
    localparam int RECIP_SHIFT  = 47;
    localparam logic [RECIP_PART_W-1:0] RECIP_LO = RECIP_PART_W'(62487);
    localparam logic [RECIP_PART_W-1:0] RECIP_HI = RECIP_PART_W'(68719);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // accept an item: store it, restart the sum
        logic rd;         // read the next history entry
        logic div_start;  // start the divide of the sum by the window
        logic avg_load;   // capture the average
        logic mul;        // capture average times speed
        logic scl_lo;     // scaling: product times the low reciprocal half
        logic scl_hi;     // scaling: add product times the high reciprocal half
        logic out_load;   // capture the distance into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rd_end;     // all window entries have been read
        logic div_done;   // divider quotient is ready
    } t_dp_sts;

endpackage

FILE: sv/echo_time_average_to_distance.sv
// An item passes through the window read, the serial divide by the effective window,
// the multiply by the speed and the scaling before its result is valid.
// Throughput: one item at a time; the next item is taken in the cycle after the result
// enters the output register, and that load waits while a previous result is pending.
// The window read and the serial divide set the item rate.
// Reset: synchronous, active low; empties history and pointer, presets the two registers.
`timescale 1ns / 1ps

module echo_time_average_to_distance #(
    parameter int MAX_WINDOW = etad_pkg::MAX_WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [etad_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [etad_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [etad_pkg::ECHO_W-1:0]     i_echo_cycles,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [etad_pkg::DIST_W-1:0]     o_distance_cm
);

    etad_pkg::t_dp_cmd w_cmd;
    etad_pkg::t_dp_sts w_sts;

    // Sequencer.
    etad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Arithmetic and storage.
    etad_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_echo_cycles (i_echo_cycles),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_distance_cm (o_distance_cm)
    );

    // A sample is stored only on an accepted item.
    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> (i_in_valid && o_in_ready))
        else $error("history written without an accepted item");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item accepted while one is in work");

    // A pending result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("output register loaded while a result waits");

    // A result appears only after the output register was loaded.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.out_load))
        else $error("result valid without an output load");

endmodule

FILE: sv/etad_div.sv
// Restoring divider, one quotient bit per cycle.
// Uses no package items; instantiated by the datapath.
`timescale 1ns / 1ps

module etad_div #(
    parameter int DIVIDEND_W = 36,
    parameter int DIVISOR_W  = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [DIVISOR_W:0]    w_shift;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_ge;

    // One trial subtraction of the divisor from the shifted remainder.
    assign w_shift = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    // Step counter and done flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Remainder and quotient; the quotient register shifts the dividend out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: sv/etad_dp.sv
// Datapath: configuration registers, sample history, sum, divider, multiply, scaling, output.
// Depends on etad_pkg and etad_div.
`timescale 1ns / 1ps

module etad_dp #(
    parameter int MAX_WINDOW = etad_pkg::MAX_WINDOW_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [etad_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [etad_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [etad_pkg::ECHO_W-1:0]      i_echo_cycles,
    input  etad_pkg::t_dp_cmd                i_cmd,
    output etad_pkg::t_dp_sts                o_sts,
    output logic [etad_pkg::DIST_W-1:0]      o_distance_cm
);

    localparam int ECHO_W = etad_pkg::ECHO_W;
    localparam int WREG_W = etad_pkg::WIN_REG_W;
    localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int EXT_W  = (WREG_W > CNT_W) ? WREG_W : CNT_W;
    localparam int SUM_W  = ECHO_W + IDX_W;
    localparam int SCL_W  = etad_pkg::SCALED_W;
    localparam int RCP_W  = etad_pkg::RECIP_PART_W;
    localparam int PP_W   = SCL_W + RCP_W;
    localparam int ACC_W  = SCL_W + 2 * RCP_W;

    logic [WREG_W-1:0]             r_win_len;
    logic [etad_pkg::SPEED_W-1:0]  r_speed;
    logic [IDX_W-1:0]              r_wp;
    logic [MAX_WINDOW-1:0]         r_valid;
    logic [ECHO_W-1:0]             r_mem [MAX_WINDOW];
    logic [ECHO_W-1:0]             r_rd_data;
    logic                          r_rd_vld;
    logic                          r_rd_live;
    logic [CNT_W-1:0]              r_rd_addr;
    logic [SUM_W-1:0]              r_sum;
    logic [ECHO_W-1:0]             r_avg;
    logic [etad_pkg::PROD_W-1:0]   r_prod;
    logic [ACC_W-1:0]              r_acc;
    logic [etad_pkg::DIST_W-1:0]   r_dist;

    logic [EXT_W-1:0]              w_len_ext;
    logic [CNT_W-1:0]              w_eff;
    logic [IDX_W-1:0]              w_wp;
    logic [CNT_W-1:0]              w_wp_inc;
    logic [IDX_W-1:0]              w_wp_next;
    logic [etad_pkg::PROD_W-1:0]   w_prod;
    logic [SUM_W-1:0]              w_quo;
    logic                          w_div_done;
    logic [SCL_W-1:0]              w_scaled;
    logic [RCP_W-1:0]              w_rcp_part;
    logic [PP_W-1:0]               w_pp;

    // Effective window: zero acts as one, values above the depth saturate.
    assign w_len_ext = EXT_W'(r_win_len);
    always_comb begin
        if (w_len_ext == '0) begin
            w_eff = CNT_W'(1);
        end else if (w_len_ext > EXT_W'(MAX_WINDOW)) begin
            w_eff = CNT_W'(MAX_WINDOW);
        end else begin
            w_eff = CNT_W'(w_len_ext);
        end
    end

    // Write slot for the new sample and the pointer after it.
    assign w_wp      = (CNT_W'(r_wp) >= w_eff) ? '0 : r_wp;
    assign w_wp_inc  = CNT_W'(w_wp) + 1'b1;
    assign w_wp_next = (w_wp_inc >= w_eff) ? '0 : w_wp_inc[IDX_W-1:0];

    // Configuration registers, write pointer and entry valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= etad_pkg::WINDOW_RESET;
            r_speed   <= etad_pkg::SPEED_RESET;
            r_wp      <= '0;
            r_valid   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                etad_pkg::REG_WINDOW_LENGTH: begin
                    r_win_len <= i_cfg_data[WREG_W-1:0];
                    r_wp      <= '0;
                    r_valid   <= '0;
                end
                etad_pkg::REG_SOUND_SPEED: begin
                    r_speed <= i_cfg_data[etad_pkg::SPEED_W-1:0];
                end
            endcase
        end else if (i_cmd.load) begin
            r_valid[w_wp] <= 1'b1;
            r_wp          <= w_wp_next;
        end
    end

    // History memory with registered read; entries never written are flagged invalid.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[w_wp] <= i_echo_cycles;
        end
        r_rd_data <= r_mem[r_rd_addr[IDX_W-1:0]];
        r_rd_vld  <= r_valid[r_rd_addr[IDX_W-1:0]];
    end

    // Read address sweep over the window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr <= '0;
            r_rd_live <= 1'b0;
        end else begin
            r_rd_live <= i_cmd.rd;
            if (i_cmd.load) begin
                r_rd_addr <= '0;
            end else if (i_cmd.rd) begin
                r_rd_addr <= r_rd_addr + 1'b1;
            end
        end
    end

    // Running sum of the valid entries read back.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sum <= '0;
        end else if (r_rd_live && r_rd_vld) begin
            r_sum <= r_sum + SUM_W'(r_rd_data);
        end
    end

    // Serial divider for the sum by the window length.
    etad_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (w_eff),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Average times speed.
    assign w_prod = etad_pkg::PROD_W'(r_avg) * etad_pkg::PROD_W'(r_speed);

    // Scaling by the reciprocal of 15625, one half of the reciprocal per cycle.
    assign w_scaled   = r_prod[etad_pkg::PROD_W-1:etad_pkg::SCALE_SHIFT];
    assign w_rcp_part = i_cmd.scl_hi ? etad_pkg::RECIP_HI : etad_pkg::RECIP_LO;
    assign w_pp       = PP_W'(w_scaled) * PP_W'(w_rcp_part);

    // Average, product, scaling accumulator and output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.avg_load) begin
            r_avg <= w_quo[ECHO_W-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.scl_lo) begin
            r_acc <= ACC_W'(w_pp);
        end else if (i_cmd.scl_hi) begin
            r_acc <= r_acc + {w_pp, RCP_W'(0)};
        end
        if (i_cmd.out_load) begin
            r_dist <= r_acc[etad_pkg::RECIP_SHIFT +: etad_pkg::DIST_W];
        end
    end

    assign o_sts.rd_end   = (r_rd_addr == w_eff);
    assign o_sts.div_done = w_div_done;
    assign o_distance_cm  = r_dist;

endmodule

FILE: sv/etad_ctrl.sv
// Controller state machine: sequences read, sum, divide, multiply, scale, output.
// Depends on etad_pkg for the command and status structs.
`timescale 1ns / 1ps

module etad_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  etad_pkg::t_dp_sts  i_sts,
    output etad_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_DST1 = 3'd2;
    localparam logic [2:0] S_DIV1 = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_SCL1 = 3'd5;
    localparam logic [2:0] S_SCL2 = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SUM;
                end
            end
            S_SUM: begin
                if (i_sts.rd_end) begin
                    n_state = S_DST1;
                end else begin
                    o_cmd.rd = 1'b1;
                end
            end
            S_DST1: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV1;
            end
            S_DIV1: begin
                if (i_sts.div_done) begin
                    o_cmd.avg_load = 1'b1;
                    n_state        = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SCL1;
            end
            S_SCL1: begin
                o_cmd.scl_lo = 1'b1;
                n_state      = S_SCL2;
            end
            S_SCL2: begin
                o_cmd.scl_hi = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
